// ===== hw/rtl/itd_pkg.sv =====
// Shared types and constants for the decimal ASCII converter.
// No dependencies; imported by itd_bcd_conv and integer_to_decimal_ascii_core.
`default_nettype none

package itd_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/itd_bcd_conv.sv =====
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on itd_pkg for the status struct.
`default_nettype none

module itd_bcd_conv #(
    parameter int WORD_BITS  = 32,
    parameter int NUM_DIGITS = 10
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [WORD_BITS-1:0]      mag,
    output itd_pkg::conv_stat_t            stat,
    output logic      [NUM_DIGITS*4-1:0]   bcd
);
    import itd_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0]    bin_reg, bin_next;
    logic [NUM_DIGITS*4-1:0] bcd_reg, bcd_next;
    logic [NUM_DIGITS*4-1:0] bcd_adj;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(WORD_BITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {bcd_adj[NUM_DIGITS*4-2:0], bin_reg[WORD_BITS-1]};
            bin_next = {bin_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_decimal_ascii_core.sv =====
// Top level: binary word in, decimal ASCII characters out, sign handling.
// Depends on itd_pkg and itd_bcd_conv.
//
//   channel | direction | beat contents
//   s_      | in        | s_value_bits (32b word)
//   m_      | out       | m_char_code (ASCII), m_last_char
//   cfg_    | in        | cfg_wr_data = signed_mode, no handshake
//
// A word is accepted and shifted bit by bit through the BCD unit, then the
// leading digit is located, then one character per cycle (1..11) goes out
// while the output does not stall.
// s_ready is high only while no conversion runs; the last character may still
// sit in the output register while the next word is accepted.
// Reset (synchronous, active low) sets signed_mode to 1 and empties the output.
`default_nettype none

module integer_to_decimal_ascii_core #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [itd_pkg::VALUE_W-1:0]   s_value_bits,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [itd_pkg::CHAR_W-1:0]    m_char_code,
    output logic                               m_last_char
);
    import itd_pkg::*;

    localparam int NUM_DIGITS = ((WORD_BITS * 1233) >> 12) + 1;
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    state_t                  state_reg, state_next;
    logic                    signed_mode_reg;
    logic                    neg_reg, neg_next;
    logic                    sign_pend_reg, sign_pend_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]       m_char_reg, m_char_next;
    logic                    m_last_reg, m_last_next;

    logic [WORD_BITS-1:0]    word_in;
    logic                    in_neg;
    logic [WORD_BITS-1:0]    in_mag;
    logic                    accept;
    logic                    out_free;
    logic [IDX_W-1:0]        lead_idx;
    logic [3:0]              cur_digit;
    conv_stat_t              conv_stat;
    logic [NUM_DIGITS*4-1:0] bcd;

    assign word_in = s_value_bits[WORD_BITS-1:0];
    assign in_neg  = signed_mode_reg & word_in[WORD_BITS-1];
    assign in_mag  = in_neg ? (~word_in + 1'b1) : word_in;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;
    assign out_free = !m_valid_reg || m_ready;

    itd_bcd_conv #(
        .WORD_BITS  (WORD_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .mag     (in_mag),
        .stat    (conv_stat),
        .bcd     (bcd)
    );

    // highest nonzero digit; zero keeps index 0
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    assign cur_digit = bcd[{idx_reg, 2'b00} +: 4];

    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        idx_next       = idx_reg;
        m_valid_next   = m_valid_reg;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next   = in_neg;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_stat.done) begin
                    idx_next       = lead_idx;
                    sign_pend_next = neg_reg;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sign_pend_reg) begin
                        m_char_next    = CHAR_MINUS;
                        m_last_next    = 1'b0;
                        sign_pend_next = 1'b0;
                    end else begin
                        m_char_next = CHAR_ZERO + {4'd0, cur_digit};
                        m_last_next = (idx_reg == '0);
                        if (idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        neg_reg       <= neg_next;
        sign_pend_reg <= sign_pend_next;
        idx_reg       <= idx_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            signed_mode_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                signed_mode_reg <= cfg_wr_data;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last_char = m_last_reg;

    // assertions
    a_accept_starts_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> conv_stat.busy)
        else $error("conversion did not start after accepted beat");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_stat.busy |-> !s_ready)
        else $error("input ready while conversion runs");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_char_code >= CHAR_ZERO && m_char_code <= CHAR_ZERO + 8'd9)
                     || m_char_code == CHAR_MINUS))
        else $error("output character is neither digit nor minus");

    a_minus_never_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_char_code == CHAR_MINUS) |-> !m_last_char)
        else $error("minus sign marked as last character");

endmodule

`default_nettype wire

// ===== verif/integer_to_decimal_ascii_core_tb.sv =====
// Self-checking testbench for integer_to_decimal_ascii_core: directed table, then random words
// under bursty input and a stalling output. Needs itd_pkg, itd_bcd_conv and the core RTL only.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_core_tb;
    import itd_pkg::*;

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;
    localparam int   IDLE_LIMIT    = 3000;
    localparam int   LONG_HOLD     = 400;
    localparam int   RAND_PHASES   = 8;
    localparam int   PHASE_WORDS   = 50;
    localparam int   N_ROWS        = 22;

    typedef struct {
        logic               mode;
        logic [VALUE_W-1:0] word;
        string              text;   // empty: expected text comes from the predictor
    } dec_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value_bits = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CHAR_W-1:0]   m_char_code;
    logic                m_last_char;

    logic [CHAR_W-1:0]   exp_char_q [$];
    logic                exp_last_q [$];
    logic                sign_mode_now = MODE_SIGNED;
    int                  err_count = 0;
    int                  words_sent = 0;
    int                  neg_words = 0;
    int                  unsigned_words = 0;
    int                  chars_checked = 0;
    int                  burst_left = 0;
    int                  idle_cycles = 0;

    logic [VALUE_W-1:0]  pow10 [10] = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000,
                                        32'd100000, 32'd1000000, 32'd10000000,
                                        32'd100000000, 32'd1000000000};

    dec_row_t dir_rows [N_ROWS] = '{
        '{MODE_SIGNED,   32'h0000_0000, "0"},
        '{MODE_SIGNED,   32'h0000_0001, "1"},
        '{MODE_SIGNED,   32'h0000_0009, "9"},
        '{MODE_SIGNED,   32'h0000_000A, "10"},
        '{MODE_SIGNED,   32'h7FFF_FFFF, "2147483647"},
        '{MODE_SIGNED,   32'h8000_0000, "-2147483648"},
        '{MODE_SIGNED,   32'h8000_0001, "-2147483647"},
        '{MODE_SIGNED,   32'hFFFF_FFFF, "-1"},
        '{MODE_SIGNED,   32'hFFFF_FFF6, "-10"},
        '{MODE_SIGNED,   32'd1000000000, "1000000000"},
        '{MODE_SIGNED,   32'd999999999, ""},
        '{MODE_SIGNED,   32'hAAAA_AAAA, ""},
        '{MODE_SIGNED,   32'h5555_5555, ""},
        '{MODE_UNSIGNED, 32'hFFFF_FFFF, "4294967295"},
        '{MODE_UNSIGNED, 32'h8000_0000, "2147483648"},
        '{MODE_UNSIGNED, 32'h0000_0000, "0"},
        '{MODE_UNSIGNED, 32'hFFFF_FFF6, ""},
        '{MODE_UNSIGNED, 32'd1234567890, ""},
        '{MODE_UNSIGNED, 32'hAAAA_AAAA, ""},
        '{MODE_UNSIGNED, 32'h5555_5555, ""},
        '{MODE_SIGNED,   32'hFFFF_FF9C, "-100"},
        '{MODE_SIGNED,   32'd4000000000, ""}
    };

    integer_to_decimal_ascii_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value_bits (s_value_bits),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_code  (m_char_code),
        .m_last_char  (m_last_char)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Decimal text of one word under the current sign mode, queued msd first.
    function automatic void queue_decimal_text(input logic [VALUE_W-1:0] w);
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digs [10];
        int                 nd;
        neg = (sign_mode_now == MODE_SIGNED) && w[VALUE_W-1];
        mag = neg ? (~w + 1'b1) : w;
        nd  = 0;
        do begin
            digs[nd] = 4'(mag % 10);
            mag      = mag / 10;
            nd++;
        end while (mag != 0 && nd < 10);
        if (neg) begin
            exp_char_q.push_back(CHAR_MINUS);
            exp_last_q.push_back(1'b0);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            exp_char_q.push_back(CHAR_ZERO + CHAR_W'(digs[k]));
            exp_last_q.push_back(k == 0);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_word();
        logic [VALUE_W-1:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = $urandom();
            4: w = $urandom_range(0, 20);
            5: w = 32'd0 - $urandom_range(1, 20);
            6: w = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
            7: w = 32'd0 - (pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1);
            8: begin
                case ($urandom_range(0, 5))
                    0: w = 32'h0000_0000;
                    1: w = 32'h7FFF_FFFF;
                    2: w = 32'h8000_0000;
                    3: w = 32'h8000_0001;
                    4: w = 32'hFFFF_FFFF;
                    default: w = 32'hFFFF_FFFE;
                endcase
            end
            default: w = $urandom() >> $urandom_range(0, 31);
        endcase
        return w;
    endfunction

    // Entered and left at a falling edge; the word is offered until accepted.
    task automatic send_word(input logic [VALUE_W-1:0] w, input string text);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 20);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_value_bits <= w;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        words_sent++;
        if (sign_mode_now == MODE_UNSIGNED) unsigned_words++;
        else if (w[VALUE_W-1]) neg_words++;
        if (text.len() == 0) begin
            queue_decimal_text(w);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                exp_char_q.push_back(CHAR_W'(text[i]));
                exp_last_q.push_back(i == text.len() - 1);
            end
        end
        @(negedge aclk);
    endtask

    // Mode is only changed with the core empty: every word yields at least one beat.
    task automatic set_sign_mode(input logic mode);
        s_valid <= 1'b0;
        while (exp_char_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= mode;
        sign_mode_now  = mode;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // first rows run on the reset value of the mode register
        for (int r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].mode != sign_mode_now) set_sign_mode(dir_rows[r].mode);
            send_word(dir_rows[r].word, dir_rows[r].text);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) set_sign_mode(MODE_UNSIGNED);
            else if (p == 1) set_sign_mode(MODE_SIGNED);
            else set_sign_mode(logic'($urandom_range(0, 1)));
            for (int i = 0; i < PHASE_WORDS; i++) send_word(pick_word(), "");
        end

        s_valid <= 1'b0;
        while (exp_char_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Sent %0d words (%0d negative, %0d in unsigned mode), checked %0d characters",
                 words_sent, neg_words, unsigned_words, chars_checked);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Test completed with failures");
        end
        $finish;
    end

    // Output side: changing stall styles, plus one long hold to back up the input.
    initial begin
        int  style;
        int  style_left;
        bit  hold_done;
        style      = 0;
        style_left = 0;
        hold_done  = 0;
        forever begin
            @(negedge aclk);
            if (!hold_done && chars_checked >= 120) begin
                hold_done = 1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(50, 200);
                end
                style_left--;
                case (style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= logic'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            chars_checked++;
            if (exp_char_q.size() == 0) begin
                $display("%0t: unexpected beat, got char %h last %b",
                         $time, m_char_code, m_last_char);
                err_count++;
            end else begin
                if (m_char_code !== exp_char_q[0]) begin
                    $display("%0t: char_code mismatch, expected %h got %h",
                             $time, exp_char_q[0], m_char_code);
                    err_count++;
                end
                if (m_last_char !== exp_last_q[0]) begin
                    $display("%0t: last_char mismatch, expected %b got %b",
                             $time, exp_last_q[0], m_last_char);
                    err_count++;
                end
                void'(exp_char_q.pop_front());
                void'(exp_last_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d characters still expected",
                         $time, IDLE_LIMIT, exp_char_q.size());
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
